### rtl/core/ptmmp_pkg.sv
// Shared types and constants of the port-tagged MIDI message parser.
// Used by ptmmp_in_stage, ptmmp_parser and the top level; no dependencies.
package ptmmp_pkg;

    // ports numbered at or above this value void the rest of the transfer
    localparam int NUM_PORTS = 8;

    // status byte codes
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYS_F4      = 8'hF4;
    localparam logic [7:0] ST_SYS_F5      = 8'hF5;
    localparam logic [3:0] CMD_SYSTEM     = 4'hF;
    localparam logic [3:0] CMD_PROG_CHG   = 4'hC;
    localparam logic [3:0] CMD_CHAN_PRESS = 4'hD;

    // message kinds reported on a result beat
    typedef enum logic [1:0] {
        KIND_CH_TWO    = 2'd0,
        KIND_CH_ONE    = 2'd1,
        KIND_SYS_SYSEX = 2'd2,
        KIND_SYS_OTHER = 2'd3
    } t_kind;

    // one input beat after the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_of_transfer;
    } t_in_beat;

    // one decoded message
    typedef struct packed {
        t_kind       msg_kind;
        logic [2:0]  port_number;
        logic [7:0]  status_value;
        logic [3:0]  command_nibble;
        logic [3:0]  channel_number;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] channel_msg_total;
    } t_result;

endpackage

### rtl/core/ptmmp_in_stage.sv
// Input register of the parser: holds one byte beat until the parser takes it.
// Depends on ptmmp_pkg for the beat type.
module ptmmp_in_stage
    import ptmmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_of_transfer,
    output logic       o_in_stall,
    input  logic       i_take,
    output logic       o_valid,
    output t_in_beat   o_beat
);

    logic     r_valid;
    t_in_beat r_beat;
    logic     w_load;

    // stall only while a held beat cannot move on
    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // beat payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_beat.in_byte          <= i_in_byte;
            r_beat.last_of_transfer <= i_last_of_transfer;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### rtl/core/ptmmp_parser.sv
// Phase machine, held message fields, message counter and result register.
// Depends on ptmmp_pkg for constants, the beat type and the result type.
module ptmmp_parser
    import ptmmp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_take,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_result  o_result
);

    typedef enum logic [2:0] {
        PH_PORT     = 3'd0,
        PH_STATUS   = 3'd1,
        PH_DATA_A   = 3'd2,
        PH_DATA_B   = 3'd3,
        PH_DATA_ONE = 3'd4,
        PH_DISCARD  = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_port, n_port;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_data, n_data;
    logic [31:0] r_total, n_total;
    logic        r_out_valid;
    t_result     r_result, n_result;
    logic        n_emit;
    logic        w_step;
    logic [7:0]  w_b;

    // result register free or draining this cycle
    assign o_take = !r_out_valid || !i_out_stall;
    assign w_step = i_valid && o_take;
    assign w_b    = i_beat.in_byte;

    // decode one byte against the current phase
    always_comb begin
        n_phase  = PH_PORT;
        n_port   = r_port;
        n_status = r_status;
        n_data   = r_data;
        n_total  = r_total;
        n_emit   = 1'b0;
        n_result.msg_kind          = KIND_CH_TWO;
        n_result.port_number       = r_port;
        n_result.status_value      = r_status;
        n_result.command_nibble    = r_status[7:4];
        n_result.channel_number    = r_status[3:0];
        n_result.first_data        = 8'd0;
        n_result.second_data       = 8'd0;
        n_result.channel_msg_total = r_total;
        case (r_phase)
            PH_STATUS: begin
                n_status = w_b;
                n_result.status_value   = w_b;
                n_result.command_nibble = w_b[7:4];
                n_result.channel_number = w_b[3:0];
                if (w_b[7:4] == CMD_SYSTEM) begin
                    n_emit = 1'b1;
                    if (w_b inside {ST_SYSEX_START, ST_SYS_F4, ST_SYS_F5}) begin
                        n_result.msg_kind = KIND_SYS_SYSEX;
                    end else begin
                        n_result.msg_kind = KIND_SYS_OTHER;
                    end
                end else if (w_b[7]) begin
                    if (w_b[7:4] inside {CMD_PROG_CHG, CMD_CHAN_PRESS}) begin
                        n_phase = PH_DATA_ONE;
                    end else begin
                        n_phase = PH_DATA_A;
                    end
                end
            end
            PH_DATA_A: begin
                n_data  = w_b;
                n_phase = PH_DATA_B;
            end
            PH_DATA_B: begin
                n_total = r_total + 32'd1;
                n_emit  = 1'b1;
                n_result.msg_kind          = KIND_CH_TWO;
                n_result.first_data        = r_data;
                n_result.second_data       = w_b;
                n_result.channel_msg_total = n_total;
            end
            PH_DATA_ONE: begin
                n_total = r_total + 32'd1;
                n_emit  = 1'b1;
                n_result.msg_kind          = KIND_CH_ONE;
                n_result.first_data        = w_b;
                n_result.channel_msg_total = n_total;
            end
            PH_DISCARD: begin
                n_phase = PH_DISCARD;
            end
            default: begin
                // port byte; unused phase codes land here too
                if ({1'b0, w_b[3:0]} >= 5'(NUM_PORTS)) begin
                    n_phase = PH_DISCARD;
                end else begin
                    n_port  = w_b[2:0];
                    n_phase = PH_STATUS;
                end
            end
        endcase
        // every transfer restarts at the port byte
        if (i_beat.last_of_transfer) begin
            n_phase = PH_PORT;
        end
    end

    // parser state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PORT;
            r_port      <= 3'd0;
            r_status    <= 8'd0;
            r_data      <= 8'd0;
            r_total     <= 32'd0;
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= w_step && n_emit;
            if (w_step) begin
                r_phase  <= n_phase;
                r_port   <= n_port;
                r_status <= n_status;
                r_data   <= n_data;
                r_total  <= n_total;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_step && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### rtl/core/port_tagged_midi_message_parser_top.sv
// Port-tagged MIDI message parser, top level.
// Input channel: one byte beat per cycle (i_in_byte, i_last_of_transfer) with
//   i_in_valid / o_in_stall; a beat is taken when valid is high and stall low.
// Output channel: one decoded message per beat with o_out_valid / i_out_stall.
// Each message in a transfer is a port byte, a status byte and zero, one or
//   two data bytes; system status bytes give a result at once, channel
//   messages give one when their last data byte arrives and bump a wrapping
//   32-bit channel message count. Cut-off messages give nothing.
// Path: a taken byte sits in the input register, is decoded there and its
//   result is captured in the result register once that register is free.
// Throughput: one byte per clock unless stalled; the phase decode is a single
//   short combinational step between the input and the result register.
// Stall: a waiting result holds the result register; the input register then
//   holds its byte and o_in_stall rises only while it is occupied, so one
//   more byte is still taken behind a stalled result.
// Reset (synchronous, active low): parser expects a port byte, the count and
//   held fields clear, and both registers empty.
// Depends on ptmmp_pkg, ptmmp_in_stage and ptmmp_parser.
module port_tagged_midi_message_parser_top
    import ptmmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_of_transfer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_msg_kind,
    output logic [2:0]  o_port_number,
    output logic [7:0]  o_status_value,
    output logic [3:0]  o_command_nibble,
    output logic [3:0]  o_channel_number,
    output logic [7:0]  o_first_data,
    output logic [7:0]  o_second_data,
    output logic [31:0] o_channel_msg_total
);

    logic     w_take;
    logic     w_beat_valid;
    t_in_beat w_beat;
    t_result  w_result;

    // input register
    ptmmp_in_stage u_in_stage (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_byte          (i_in_byte),
        .i_last_of_transfer (i_last_of_transfer),
        .o_in_stall         (o_in_stall),
        .i_take             (w_take),
        .o_valid            (w_beat_valid),
        .o_beat             (w_beat)
    );

    // phase machine and result register
    ptmmp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_beat_valid),
        .i_beat      (w_beat),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    // result fields to ports
    assign o_msg_kind          = w_result.msg_kind;
    assign o_port_number       = w_result.port_number;
    assign o_status_value      = w_result.status_value;
    assign o_command_nibble    = w_result.command_nibble;
    assign o_channel_number    = w_result.channel_number;
    assign o_first_data        = w_result.first_data;
    assign o_second_data       = w_result.second_data;
    assign o_channel_msg_total = w_result.channel_msg_total;

endmodule
